[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/dpr_pkg.sv]
// Shared constants for the pending request table.
package dpr_pkg;

    localparam int OP_W     = 3;
    localparam int TAG_W    = 32;
    localparam int ENTRY_W  = 2 * TAG_W;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 6;
    localparam int COUNT_W  = 7;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam logic [COUNT_W-1:0] CAP_RESET = 7'd16;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_UADD   = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
    localparam logic [OP_W-1:0] OP_DRAIN  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

endpackage

[hw/rtl/dedup_pending_request_table.sv]
// Top level of the deduplicating pending request table.
//
// Command channel: a transaction is taken at a clock edge with start high and
// busy low; op, handler_tag and context_tag are sampled at that edge.
// Results leave on the result ports for one cycle each, marked by done; the
// receiver cannot stall them. Drain gives one result per entry (last on the
// final one, or one if empty); every other op gives exactly one result.
// Add, an unused op, an empty drain and a search on an empty table answer
// straight from idle. Unique add / find / remove compare one entry at a time
// on the shared 64-bit comparator; a remove then closes up the table, moving
// each later entry by one RAM read and one RAM write through the single
// table memory. A drain gives one entry every cycle.
// busy stays high until the final result is loaded; the next transaction may
// be taken in the cycle that shows that result. The user writes the capacity
// limit through cfg_we / capacity_limit only while idle; nothing enforces it.
// Reset empties the table, clears the overflow flag and sets the limit to 16;
// table memory is not cleared, since only written entries are ever read.
module dedup_pending_request_table
    import dpr_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     op,
    input  logic [TAG_W-1:0]    handler_tag,
    input  logic [TAG_W-1:0]    context_tag,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  capacity_limit,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [FOUND_W-1:0]  found_index,
    output logic [TAG_W-1:0]    out_handler_tag,
    output logic [TAG_W-1:0]    out_context_tag,
    output logic                entry_valid,
    output logic [COUNT_W-1:0]  pending_count,
    output logic                overflow_seen,
    output logic                last
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(TABLE_DEPTH);
    localparam logic [COUNT_W-1:0] ONE_C   = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] TWO_C   = COUNT_W'(2);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SRCH_RD  = 3'd1;
    localparam logic [2:0] S_SRCH_CMP = 3'd2;
    localparam logic [2:0] S_SHIFT_RD = 3'd3;
    localparam logic [2:0] S_SHIFT_WR = 3'd4;
    localparam logic [2:0] S_DRAIN    = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [COUNT_W-1:0]  cap_reg;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [COUNT_W-1:0]  idx_reg, idx_next;
    logic [COUNT_W-1:0]  n_reg, n_next;
    logic                dovf_reg, dovf_next;
    logic                pend_reg, pend_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [ENTRY_W-1:0]  key_reg, key_next;

    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [FOUND_W-1:0]  found_reg, found_next;
    logic [TAG_W-1:0]    oh_reg, oh_next;
    logic [TAG_W-1:0]    oc_reg, oc_next;
    logic                ev_reg, ev_next;
    logic [COUNT_W-1:0]  pc_reg, pc_next;
    logic                os_reg, os_next;
    logic                last_reg, last_next;

    logic [COUNT_W-1:0]  lim;
    logic [ENTRY_W-1:0]  key;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic                match;
    logic                do_app;
    logic                gen_emit;
    logic [STATUS_W-1:0] em_status;
    logic [FOUND_W-1:0]  em_idx;

    dpr_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign lim   = (cap_reg > DEPTH_C) ? DEPTH_C : cap_reg;
    assign key   = (state_reg == S_IDLE) ? {handler_tag, context_tag} : key_reg;
    assign match = (ram_rdata == key_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        dovf_next   = dovf_reg;
        pend_next   = 1'b0;
        op_next     = op_reg;
        key_next    = key_reg;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[IDX_W-1:0];
        ram_wdata   = key;
        ram_raddr   = idx_reg[IDX_W-1:0];
        do_app      = 1'b0;
        gen_emit    = 1'b0;
        em_status   = ST_OK;
        em_idx      = '0;
        done_next   = 1'b0;
        status_next = ST_OK;
        found_next  = '0;
        oh_next     = '0;
        oc_next     = '0;
        ev_next     = 1'b0;
        pc_next     = count_reg;
        os_next     = 1'b0;
        last_next   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = op;
                    key_next = {handler_tag, context_tag};
                    idx_next = '0;
                    unique case (op)
                        OP_ADD:
                        begin
                            do_app = 1'b1;
                        end
                        OP_UADD, OP_REMOVE, OP_FIND:
                        begin
                            if (count_reg == '0)
                            begin
                                if (op == OP_UADD)
                                begin
                                    do_app = 1'b1;
                                end
                                else
                                begin
                                    gen_emit  = 1'b1;
                                    em_status = ST_MISS;
                                end
                            end
                            else
                            begin
                                state_next = S_SRCH_RD;
                            end
                        end
                        OP_DRAIN:
                        begin
                            n_next     = count_reg;
                            dovf_next  = ovf_reg;
                            ovf_next   = 1'b0;
                            count_next = '0;
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                                pc_next   = '0;
                                os_next   = ovf_reg;
                            end
                            else
                            begin
                                state_next = S_DRAIN;
                            end
                        end
                        default:
                        begin
                            gen_emit = 1'b1;
                        end
                    endcase
                end
            end
            S_SRCH_RD:
            begin
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (match)
                begin
                    priority if (op_reg == OP_UADD)
                    begin
                        gen_emit  = 1'b1;
                        em_status = ST_DUP;
                    end
                    else if (op_reg == OP_FIND)
                    begin
                        gen_emit = 1'b1;
                        em_idx   = FOUND_W'(idx_reg);
                    end
                    else if (idx_reg + ONE_C < count_reg)
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        // removing the tail entry: nothing to close up
                        count_next = count_reg - ONE_C;
                        gen_emit   = 1'b1;
                    end
                end
                else if (idx_reg + ONE_C >= count_reg)
                begin
                    if (op_reg == OP_UADD)
                    begin
                        do_app = 1'b1;
                    end
                    else
                    begin
                        gen_emit  = 1'b1;
                        em_status = ST_MISS;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + ONE_C;
                    state_next = S_SRCH_RD;
                end
            end
            S_SHIFT_RD:
            begin
                ram_raddr  = idx_next[IDX_W-1:0] + IDX_W'(1);
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                // move entry idx+1 down into idx
                ram_we    = 1'b1;
                ram_waddr = idx_reg[IDX_W-1:0];
                ram_wdata = ram_rdata;
                idx_next  = idx_reg + ONE_C;
                if (idx_reg + TWO_C < count_reg)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    count_next = count_reg - ONE_C;
                    gen_emit   = 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (idx_reg < n_reg)
                begin
                    idx_next  = idx_reg + ONE_C;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    done_next = 1'b1;
                    oh_next   = ram_rdata[ENTRY_W-1:TAG_W];
                    oc_next   = ram_rdata[TAG_W-1:0];
                    ev_next   = 1'b1;
                    pc_next   = n_reg;
                    os_next   = dovf_reg;
                    last_next = (idx_reg == n_reg);
                    if (idx_reg == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_app)
        begin
            if (count_reg >= lim)
            begin
                ovf_next  = 1'b1;
                em_status = ST_FULL;
            end
            else
            begin
                ram_we     = 1'b1;
                ram_waddr  = count_reg[IDX_W-1:0];
                ram_wdata  = key;
                count_next = count_reg + ONE_C;
            end
            gen_emit = 1'b1;
        end

        if (gen_emit)
        begin
            done_next   = 1'b1;
            status_next = em_status;
            found_next  = em_idx;
            pc_next     = count_next;
            state_next  = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                cap_reg <= capacity_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        n_reg      <= n_next;
        dovf_reg   <= dovf_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        oh_reg     <= oh_next;
        oc_reg     <= oc_next;
        ev_reg     <= ev_next;
        pc_reg     <= pc_next;
        os_reg     <= os_next;
        last_reg   <= last_next;
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign found_index     = found_reg;
    assign out_handler_tag = oh_reg;
    assign out_context_tag = oc_reg;
    assign entry_valid     = ev_reg;
    assign pending_count   = pc_reg;
    assign overflow_seen   = os_reg;
    assign last            = last_reg;

endmodule

[hw/rtl/dpr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dpr_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/dpr_checker.sv]
// Port-level checker for the pending request table, bound to the top level.
`include "assert_macros.svh"

module dpr_checker
    import dpr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                done,
    input  logic [STATUS_W-1:0] status,
    input  logic                entry_valid,
    input  logic                last
);

    // an accepted transaction either answers at once or keeps the block busy
    `DPR_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || done, "accept stalled")

    // drained entries come out back to back until the last one
    `DPR_ASSERT_NEXT(a_drain_contig, clk, rst_n, done && !last, done, "gap in drain transaction")

    // a result with more to follow leaves the block busy
    `DPR_ASSERT_NOW(a_more_busy, clk, rst_n, done && !last, busy, "idle with results pending")

    // drained entries always report ok
    `DPR_ASSERT_NOW(a_entry_ok, clk, rst_n, done && entry_valid, status == ST_OK, "entry not ok")

endmodule

bind dedup_pending_request_table dpr_checker u_dpr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .entry_valid (entry_valid),
    .last        (last)
);
